// File: hw/rtl/moving_average_rounded_macros.svh
// ----------------------------------------------------------------------------
// moving_average_rounded_macros.svh
// Assertion macros shared by the moving average RTL.
// ----------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_ROUNDED_MACROS_SVH
`define MOVING_AVERAGE_ROUNDED_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define MAR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mar: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define MAR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mar: next-cycle check failed");

`endif

// File: hw/rtl/mar_pkg.sv
// ----------------------------------------------------------------------------
// mar_pkg
// Shared widths, reset values and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package mar_pkg;

    localparam int SAMPLE_W = 32;
    localparam int CFG_W    = 7;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;    // latch sample, read oldest slot
        logic update;    // update ring, fill count and running sum
        logic prep;      // load divider from sum and count
        logic div_step;  // one quotient bit
        logic load_out;  // move rounded result into output register
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic div_last;  // final quotient bit this cycle
        logic out_free;  // output register can take a result this cycle
    } t_sts;

endpackage

// File: hw/rtl/mar_sample_if.sv
// ----------------------------------------------------------------------------
// mar_sample_if
// Valid/ready channel carrying one input sample per beat.
// ----------------------------------------------------------------------------
interface mar_sample_if;

    logic                                 valid;
    logic                                 ready;
    logic signed [mar_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);

endinterface

// File: hw/rtl/mar_average_if.sv
// ----------------------------------------------------------------------------
// mar_average_if
// Valid/ready channel carrying one rounded average per beat.
// ----------------------------------------------------------------------------
interface mar_average_if;

    logic                                 valid;
    logic                                 ready;
    logic signed [mar_pkg::SAMPLE_W-1:0]  average;

    modport source (output valid, output average, input ready);
    modport sink   (input valid, input average, output ready);

endinterface

// File: hw/rtl/mar_ram.sv
// ----------------------------------------------------------------------------
// mar_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mar_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/mar_datapath.sv
// ----------------------------------------------------------------------------
// mar_datapath
// Sample ring, running sum, bit-serial rounding divider and output register.
// ----------------------------------------------------------------------------
`include "moving_average_rounded_macros.svh"

module mar_datapath #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [mar_pkg::CFG_W-1:0]            i_cfg_wdata,
    input  mar_pkg::t_cmd                        i_cmd,
    output mar_pkg::t_sts                        o_sts,
    input  logic signed [mar_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic signed [mar_pkg::SAMPLE_W-1:0]  o_average
);

    localparam int SW     = mar_pkg::SAMPLE_W;
    localparam int PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = SW + CNT_W;
    localparam int NUM_W  = SUM_W + 1;
    localparam int DEN_W  = CNT_W + 1;
    localparam int REM_W  = DEN_W + 1;
    localparam int STEP_W = $clog2(NUM_W + 1);

    logic [mar_pkg::CFG_W-1:0] r_win;
    logic [PTR_W-1:0]          r_wp;
    logic [PTR_W-1:0]          r_slot;
    logic [CNT_W-1:0]          r_fill;
    logic signed [SUM_W-1:0]   r_sum;
    logic signed [SW-1:0]      r_sample;
    logic                      r_neg;
    logic [NUM_W-1:0]          r_num;
    logic [DEN_W-1:0]          r_den;
    logic [REM_W-1:0]          r_rem;
    logic [STEP_W-1:0]         r_cnt;
    logic                      r_out_valid;
    logic signed [SW-1:0]      r_out;

    logic [CNT_W-1:0]          w_eff;
    logic [PTR_W-1:0]          w_slot;
    logic [PTR_W-1:0]          w_next_wp;
    logic                      w_full;
    logic [SW-1:0]             w_old_raw;
    logic signed [SUM_W-1:0]   w_old;
    logic signed [SUM_W-1:0]   w_new;
    logic signed [SUM_W-1:0]   n_sum;
    logic [CNT_W-1:0]          n_fill;
    logic [SUM_W-1:0]          w_mag;
    logic [REM_W-1:0]          w_rem_sh;
    logic                      w_qbit;
    logic [REM_W-1:0]          n_rem;
    logic [SW-1:0]             w_quot;

    // Clamp the programmed window to 1..MAX_WINDOW
    always_comb begin
        if (r_win == '0) begin
            w_eff = CNT_W'(1);
        end else if (int'(r_win) > MAX_WINDOW) begin
            w_eff = CNT_W'(MAX_WINDOW);
        end else begin
            w_eff = CNT_W'(r_win);
        end
    end

    // Slot for the incoming sample and the pointer after it
    assign w_slot    = (int'(r_wp) >= int'(w_eff)) ? '0 : r_wp;
    assign w_next_wp = ((int'(r_slot) + 1) >= int'(w_eff)) ? '0 : (r_slot + 1'b1);

    // Ring storage: read the oldest sample at accept, overwrite it at update
    mar_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.update),
        .i_waddr (r_slot),
        .i_wdata (r_sample),
        .i_re    (i_cmd.accept),
        .i_raddr (w_slot),
        .o_rdata (w_old_raw)
    );

    // Running sum and fill count after this sample
    always_comb begin
        w_full = int'(r_fill) >= int'(w_eff);
        w_old  = {{CNT_W{w_old_raw[SW-1]}}, w_old_raw};
        w_new  = {{CNT_W{r_sample[SW-1]}}, r_sample};
        if (w_full) begin
            n_sum  = r_sum - w_old + w_new;
            n_fill = w_eff;
        end else begin
            n_sum  = r_sum + w_new;
            n_fill = r_fill + 1'b1;
        end
    end

    // Magnitude of the sum for the divider
    assign w_mag = r_sum[SUM_W-1] ? SUM_W'(~r_sum + 1'b1) : SUM_W'(r_sum);

    // One restoring division step
    always_comb begin
        w_rem_sh = {r_rem[REM_W-2:0], r_num[NUM_W-1]};
        w_qbit   = w_rem_sh >= {1'b0, r_den};
        n_rem    = w_qbit ? (w_rem_sh - {1'b0, r_den}) : w_rem_sh;
    end

    assign w_quot = r_num[SW-1:0];

    // History, divider control and output handshake state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win       <= mar_pkg::CFG_RESET;
            r_wp        <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_win  <= i_cfg_wdata;
                r_wp   <= '0;
                r_fill <= '0;
                r_sum  <= '0;
            end else if (i_cmd.update) begin
                r_wp   <= w_next_wp;
                r_fill <= n_fill;
                r_sum  <= n_sum;
            end
            if (i_cmd.prep) begin
                r_cnt <= STEP_W'(NUM_W);
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt - 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= i_sample;
            r_slot   <= w_slot;
        end
        if (i_cmd.prep) begin
            // quotient = (2|sum| + n) / 2n rounds half away from zero
            r_neg <= r_sum[SUM_W-1];
            r_num <= {w_mag, 1'b0} + NUM_W'(r_fill);
            r_den <= {r_fill, 1'b0};
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_num <= {r_num[NUM_W-2:0], w_qbit};
            r_rem <= n_rem;
        end
        if (i_cmd.load_out) begin
            r_out <= r_neg ? signed'(~w_quot + 1'b1) : signed'(w_quot);
        end
    end

    assign o_sts.div_last = (r_cnt == STEP_W'(1));
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_average      = r_out;

    `MAR_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, int'(r_fill) <= int'(w_eff))
    `MAR_ASSERT_IMP(a_wp_bound, i_clk, i_rst_n, 1'b1, int'(r_wp) < int'(w_eff))
    `MAR_ASSERT_NEXT(a_load_valid, i_clk, i_rst_n, i_cmd.load_out, r_out_valid)

endmodule

// File: hw/rtl/mar_ctrl.sv
// ----------------------------------------------------------------------------
// mar_ctrl
// Sequencer: accept, update history, prepare and run divider, hand off result.
// ----------------------------------------------------------------------------
`include "moving_average_rounded_macros.svh"

module mar_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  mar_pkg::t_sts i_sts,
    output mar_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_PREP,
        S_DIV,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;

    // Decode commands and next state
    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_in_ready     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_PREP;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `MAR_ASSERT_NEXT(a_accept_update, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_UPDATE)
    `MAR_ASSERT_IMP(a_load_free, i_clk, i_rst_n, o_cmd.load_out, i_sts.out_free)
    `MAR_ASSERT_IMP(a_last_in_div, i_clk, i_rst_n, i_sts.div_last, r_state == S_DIV)

endmodule

// File: hw/rtl/moving_average_rounded.sv
// ----------------------------------------------------------------------------
// moving_average_rounded
// Rounded moving average of signed 32-bit samples over a programmable window.
// ----------------------------------------------------------------------------
// Usage:
//   i_sample is a valid/ready sink; one beat carries one signed sample.
//   o_average is a valid/ready source; one beat per sample, carrying the
//   average of the samples held so far, rounded half away from zero.
//   i_cfg_we/i_cfg_wdata write the window length (0 acts as 1, values above
//   MAX_WINDOW act as MAX_WINDOW) and clear the history. Write only while idle.
// Timing:
//   A new sample is taken only once the previous result has been loaded
//   into the output register. The bit-serial divider, one quotient bit per
//   cycle, takes most of the time spent on each sample.
// Reset:
//   Synchronous, active low. Window returns to 64, history is emptied.
// Stall:
//   A result waits in the output register while the next sample is taken and
//   processed; that sample's result is held back until the register frees.
// ----------------------------------------------------------------------------
module moving_average_rounded #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mar_pkg::CFG_W-1:0]     i_cfg_wdata,
    mar_sample_if.sink                    i_sample,
    mar_average_if.source                 o_average
);

    mar_pkg::t_cmd w_cmd;
    mar_pkg::t_sts w_sts;

    // Sequencer
    mar_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .o_in_ready (i_sample.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // History, divider and output register
    mar_datapath #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_sample    (i_sample.sample),
        .i_out_ready (o_average.ready),
        .o_out_valid (o_average.valid),
        .o_average   (o_average.average)
    );

endmodule
